[sv/heat_diffusion_stencil_step_core_macros.svh]
// Assertion macros for the heat diffusion step core
`ifndef HEAT_DIFFUSION_STENCIL_STEP_CORE_MACROS_SVH
`define HEAT_DIFFUSION_STENCIL_STEP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define HD_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HD_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define HD_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[sv/hds_pkg.sv]
// Shared types and constants for the heat diffusion step core
`timescale 1ns / 1ps
package hds_pkg;
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_STEP  = 2'd2;

    localparam logic [2:0] REG_COEF_COL     = 3'd0;
    localparam logic [2:0] REG_COEF_ROW     = 3'd1;
    localparam logic [2:0] REG_SOURCE_ROW   = 3'd2;
    localparam logic [2:0] REG_SOURCE_COL   = 3'd3;
    localparam logic [2:0] REG_SOURCE_TEMP  = 3'd4;
    localparam logic [2:0] REG_SOURCE_STEPS = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SWEEP,
        ST_COPY,
        ST_SOURCE,
        ST_OUT
    } state_t;
endpackage

[sv/heat_diffusion_stencil_step_core.sv]
// Top level of the heat diffusion step core
// Usage: in_valid/in_stall carry one command word (operation, cell_row,
// cell_col, write_value); out_valid/out_stall carry one result word
// (read_value, steps_taken) per command. cfg_we/cfg_index/cfg_data write the six
// setup registers; the user must write them only while the core is idle, as it does not enforce this.
// A write offers its result word in the cycle after it is taken; a read passes
// through ST_RD_WAIT and then ST_OUT offers its result word.
// A step sweeps the grid: each cell takes 7 reads of grid_now through its
// single read port plus a finish step for the arithmetic, then a copy pass
// writes grid_next back into grid_now. The single read port bounds how long
// a step takes.
// One command is in flight at a time; in_stall is high while busy.
// Reset clears the step count, registers and control; the grid memories
// are not cleared and hold undefined data until written.
// When out_stall is high the result word holds in the output register and
// in_stall stays high until it is taken.
`timescale 1ns / 1ps
`include "heat_diffusion_stencil_step_core_macros.svh"
module heat_diffusion_stencil_step_core
    import hds_pkg::*;
#(
    parameter int ROWS = 64,
    parameter int COLS = 64
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         operation,
    input  logic [5:0]         cell_row,
    input  logic [5:0]         cell_col,
    input  logic signed [31:0] write_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] read_value,
    output logic [15:0]        steps_taken,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    localparam int CELLS = ROWS * COLS;
    localparam int AW = $clog2(CELLS);
    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);

    logic signed [31:0] grid_now [CELLS];
    logic signed [31:0] grid_next [CELLS];

    state_t state_reg, state_next;
    logic [17:0] coef_col_reg, coef_row_reg;
    logic [5:0]  src_row_reg, src_col_reg;
    logic signed [31:0] src_temp_reg;
    logic [15:0] src_steps_reg, steps_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [2:0]    tap_reg;
    logic [AW:0]   copy_reg;
    logic signed [33:0] acc_c_reg, acc_r_reg;
    logic [2:0]    tap_d_reg;
    logic          rd_pend_reg;
    logic signed [31:0] out_val_reg;

    // memory ports
    logic          now_we, next_we;
    logic [AW-1:0] now_waddr, now_raddr, next_addr;
    logic signed [31:0] now_wdata, now_rdata, next_wdata, next_rdata;

    always_ff @(posedge clk)
    begin
        if (now_we)
            grid_now[now_waddr] <= now_wdata;
        now_rdata <= grid_now[now_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
            grid_next[next_addr] <= next_wdata;
        next_rdata <= grid_next[next_addr];
    end

    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign read_value  = out_val_reg;
    assign steps_taken = steps_reg;

    logic in_grid;
    assign in_grid = ({26'd0, cell_row} < 32'(ROWS)) && ({26'd0, cell_col} < 32'(COLS));
    logic [AW-1:0] cell_addr;
    assign cell_addr = AW'(32'(cell_row) * 32'(COLS) + 32'(cell_col));

    // tap address: taps 0..2 columns, 3..5 rows, 6 center
    logic [RW-1:0] tr;
    logic [CW-1:0] tc;
    logic [1:0] k;
    always_comb
    begin
        tr = row_reg;
        tc = col_reg;
        k = 2'd0;
        case (tap_reg)
            3'd0, 3'd1, 3'd2: k = 2'(tap_reg);
            3'd3, 3'd4, 3'd5: k = 2'(tap_reg - 3'd3);
            default: k = 2'd1;
        endcase
        if (tap_reg < 3'd3) begin
            if (col_reg == '0)
                tc = CW'(k);
            else if (32'(col_reg) == COLS - 1)
                tc = CW'(32'(COLS - 1) - 32'(k));
            else
                tc = CW'(32'(col_reg) + 32'(k) - 32'd1);
        end else if (tap_reg < 3'd6) begin
            if (row_reg == '0)
                tr = RW'(k);
            else if (32'(row_reg) == ROWS - 1)
                tr = RW'(32'(ROWS - 1) - 32'(k));
            else
                tr = RW'(32'(row_reg) + 32'(k) - 32'd1);
        end
    end

    // weight of each tap: middle tap of the three-point form gets -2
    logic signed [33:0] tap_term;
    always_comb
    begin
        tap_term = 34'(now_rdata);
        if (tap_d_reg == 3'd1 || tap_d_reg == 3'd4)
            tap_term = -(34'(now_rdata) <<< 1);
    end

    // final arithmetic; the center word arrives from memory in the finish cycle
    logic signed [52:0] prod_c, prod_r, psum;
    logic signed [36:0] shf;
    logic signed [37:0] nv;
    logic signed [31:0] nv_sat;
    always_comb
    begin
        prod_c = 53'(acc_c_reg) * $signed({35'd0, coef_col_reg});
        prod_r = 53'(acc_r_reg) * $signed({35'd0, coef_row_reg});
        psum = prod_c + prod_r;
        shf = 37'(psum >>> 16);
        nv = 38'(shf) + 38'(now_rdata);
        if (nv > 38'sd2147483647)
            nv_sat = 32'sh7fffffff;
        else if (nv < -38'sd2147483648)
            nv_sat = 32'sh80000000;
        else
            nv_sat = 32'(nv);
    end

    logic last_cell;
    assign last_cell = (32'(row_reg) == ROWS - 1) && (32'(col_reg) == COLS - 1);
    logic src_on;
    assign src_on = (steps_reg < src_steps_reg) && (32'(src_row_reg) < ROWS)
                    && (32'(src_col_reg) < COLS);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_acc) begin
                    if (operation == OP_READ && in_grid)
                        state_next = ST_RD_WAIT;
                    else if (operation == OP_STEP)
                        state_next = ST_SWEEP;
                    else
                        state_next = ST_OUT;
                end
            ST_RD_WAIT: state_next = ST_OUT;
            ST_SWEEP:
                if (tap_reg == 3'd7 && last_cell)
                    state_next = ST_COPY;
            ST_COPY:
                if (copy_reg == (AW+1)'(CELLS))
                    state_next = ST_SOURCE;
            ST_SOURCE: state_next = ST_OUT;
            ST_OUT:
                if (out_acc)
                    state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        now_we = 1'b0;
        now_waddr = cell_addr;
        now_wdata = write_value;
        now_raddr = cell_addr;
        next_we = 1'b0;
        next_addr = AW'(32'(row_reg) * 32'(COLS) + 32'(col_reg));
        next_wdata = nv_sat;
        case (state_reg)
            ST_IDLE:
                now_we = in_acc && operation == OP_WRITE && in_grid;
            ST_SWEEP:
            begin
                now_raddr = AW'(32'(tr) * 32'(COLS) + 32'(tc));
                next_we = (tap_reg == 3'd7);
            end
            ST_COPY:
            begin
                next_addr = copy_reg[AW-1:0];
                now_waddr = AW'(copy_reg - 1'b1);
                now_wdata = next_rdata;
                now_we = (copy_reg != '0);
            end
            ST_SOURCE:
            begin
                now_waddr = AW'(32'(src_row_reg) * 32'(COLS) + 32'(src_col_reg));
                now_wdata = src_temp_reg;
                now_we = src_on;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            coef_col_reg <= '0;
            coef_row_reg <= '0;
            src_row_reg <= '0;
            src_col_reg <= '0;
            src_temp_reg <= '0;
            src_steps_reg <= '0;
            steps_reg <= '0;
            row_reg <= '0;
            col_reg <= '0;
            tap_reg <= '0;
            copy_reg <= '0;
            rd_pend_reg <= 1'b0;
            tap_d_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_COEF_COL:     coef_col_reg <= cfg_data[17:0];
                    REG_COEF_ROW:     coef_row_reg <= cfg_data[17:0];
                    REG_SOURCE_ROW:   src_row_reg <= cfg_data[5:0];
                    REG_SOURCE_COL:   src_col_reg <= cfg_data[5:0];
                    REG_SOURCE_TEMP:  src_temp_reg <= cfg_data;
                    REG_SOURCE_STEPS: src_steps_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            rd_pend_reg <= (state_reg == ST_SWEEP) && (tap_reg < 3'd7);
            tap_d_reg <= tap_reg;
            case (state_reg)
                ST_IDLE:
                begin
                    row_reg <= '0;
                    col_reg <= '0;
                    tap_reg <= '0;
                    copy_reg <= '0;
                end
                ST_SWEEP:
                begin
                    if (tap_reg == 3'd7) begin
                        tap_reg <= '0;
                        if (32'(col_reg) == COLS - 1) begin
                            col_reg <= '0;
                            row_reg <= row_reg + 1'b1;
                        end else begin
                            col_reg <= col_reg + 1'b1;
                        end
                    end else begin
                        tap_reg <= tap_reg + 1'b1;
                    end
                end
                ST_COPY: copy_reg <= copy_reg + 1'b1;
                ST_SOURCE:
                    if (steps_reg != 16'hffff)
                        steps_reg <= steps_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // accumulate taps as they arrive from memory
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SWEEP && tap_reg == 3'd0) begin
            acc_c_reg <= '0;
            acc_r_reg <= '0;
        end
        if (rd_pend_reg) begin
            if (tap_d_reg < 3'd3)
                acc_c_reg <= (tap_d_reg == 3'd0 ? 34'sd0 : acc_c_reg) + tap_term;
            else if (tap_d_reg < 3'd6)
                acc_r_reg <= (tap_d_reg == 3'd3 ? 34'sd0 : acc_r_reg) + tap_term;
        end
        if (state_reg == ST_IDLE && in_acc)
            out_val_reg <= '0;
        else if (state_reg == ST_RD_WAIT)
            out_val_reg <= now_rdata;
    end

    `HD_ASSERT_IMPL(a_no_stall_busy, clk, rst_n, (state_reg == ST_IDLE) || in_stall, "accepted while busy")
    `HD_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(read_value), "result dropped")
    `HD_ASSERT_NEXT(a_step_count, clk, rst_n, state_reg != ST_SOURCE, steps_reg == $past(steps_reg), "step count moved")
endmodule

[tb/heat_diffusion_stencil_step_core_tb.sv]
// Self-checking testbench for the heat diffusion step core
`timescale 1ns / 1ps
module heat_diffusion_stencil_step_core_tb
    import hds_pkg::*;
();

    localparam int NROW = 64;
    localparam int NCOL = 64;
    localparam int NCELL = NROW * NCOL;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 20;
    localparam int PHASE_ITEMS = 47;
    localparam int PHASE_STEPS = 3;

    typedef struct packed {
        logic signed [31:0] temp;
        logic [15:0]        steps;
    } result_t;

    typedef struct packed {
        logic [1:0]         op;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] wval;
        logic signed [31:0] exp_temp;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         operation;
    logic [5:0]         cell_row;
    logic [5:0]         cell_col;
    logic signed [31:0] write_value;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] read_value;
    logic [15:0]        steps_taken;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    // predictor state
    int          temp_grid [NCELL];
    int          temp_next [NCELL];
    logic [15:0] step_count;
    logic [17:0] k_col;
    logic [17:0] k_row;
    logic [5:0]  src_row;
    logic [5:0]  src_col;
    int          src_temp;
    logic [15:0] src_steps;

    result_t     expected_results[$];
    int          fail_count = 0;
    int          words_checked = 0;
    int          steps_run;
    int          cycle_count = 0;
    int          burst_left;
    int          hold_left;
    bit          hold_done;
    dir_row_t    dir_tab[12];

    heat_diffusion_stencil_step_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .write_value (write_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .read_value  (read_value),
        .steps_taken (steps_taken),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic longint second_diff(int i, int k, int n, int stride);
        longint a;
        longint b;
        longint c;
        if (k == 0)
        begin
            a = temp_grid[i];
            b = temp_grid[i + stride];
            c = temp_grid[i + 2 * stride];
        end
        else if (k == n - 1)
        begin
            a = temp_grid[i];
            b = temp_grid[i - stride];
            c = temp_grid[i - 2 * stride];
        end
        else
        begin
            a = temp_grid[i - stride];
            b = temp_grid[i];
            c = temp_grid[i + stride];
        end
        return a - 2 * b + c;
    endfunction

    function automatic void diffuse_grid();
        longint acc;
        int idx;
        for (int r = 0; r < NROW; r++)
        begin
            for (int c = 0; c < NCOL; c++)
            begin
                idx = r * NCOL + c;
                acc = longint'(k_col) * second_diff(idx, c, NCOL, 1)
                    + longint'(k_row) * second_diff(idx, r, NROW, NCOL);
                acc = longint'(temp_grid[idx]) + (acc >>> 16);
                if (acc > 64'sd2147483647)
                    acc = 64'sd2147483647;
                else if (acc < -64'sd2147483648)
                    acc = -64'sd2147483648;
                temp_next[idx] = int'(acc);
            end
        end
        temp_grid = temp_next;
        if (step_count < src_steps)
            temp_grid[src_row * NCOL + src_col] = src_temp;
        if (step_count != 16'hFFFF)
            step_count++;
    endfunction

    function automatic result_t predict_word(logic [1:0] op, logic [5:0] r, logic [5:0] c,
                                             logic signed [31:0] v);
        result_t res;
        res.temp = '0;
        case (op)
            OP_WRITE: temp_grid[r * NCOL + c] = v;
            OP_READ:  res.temp = temp_grid[r * NCOL + c];
            OP_STEP:  diffuse_grid();
            default: ;
        endcase
        res.steps = step_count;
        return res;
    endfunction

    // Offer one word and hold it until taken; at the end of a burst, drop in_valid and idle before returning.
    task automatic send_word(logic [1:0] op, logic [5:0] r, logic [5:0] c,
                             logic signed [31:0] v, bit typed, logic signed [31:0] typed_temp);
        result_t res;
        in_valid    <= 1'b1;
        operation   <= op;
        cell_row    <= r;
        cell_col    <= c;
        write_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = predict_word(op, r, c, v);
        if (op == OP_STEP)
            steps_run++;
        if (typed)
            res.temp = typed_temp;
        expected_results.push_back(res);
        // idle between bursts
        if (burst_left == 0)
        begin
            in_valid   <= 1'b0;
            burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_COEF_COL:     k_col = data[17:0];
            REG_COEF_ROW:     k_row = data[17:0];
            REG_SOURCE_ROW:   src_row = data[5:0];
            REG_SOURCE_COL:   src_col = data[5:0];
            REG_SOURCE_TEMP:  src_temp = data;
            REG_SOURCE_STEPS: src_steps = data[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase();
        int taken;
        int roll;
        logic [1:0] op;
        taken = 0;
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (taken < PHASE_STEPS && (roll < 7 || PHASE_ITEMS - n <= PHASE_STEPS - taken))
            begin
                op = OP_STEP;
                taken++;
            end
            else if (roll < 45)
                op = OP_WRITE;
            else if (roll < 94)
                op = OP_READ;
            else
                op = OP_UNUSED;
            send_word(op, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      $urandom(), 1'b0, '0);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_checked++;
            if (expected_results.size() == 0)
            begin
                $error("result word with nothing expected: read_value %h steps_taken %0d",
                       read_value, steps_taken);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (read_value !== want.temp)
                begin
                    $error("read_value expected %h actual %h", want.temp, read_value);
                    fail_count++;
                end
                if (steps_taken !== want.steps)
                begin
                    $error("steps_taken expected %0d actual %0d", want.steps, steps_taken);
                    fail_count++;
                end
            end
        end
    end

    // receiver stall pattern, with one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && words_checked == 30)
        begin
            out_stall <= 1'b1;
            hold_left <= 400;
            hold_done <= 1'b1;
        end
        else if (cycle_count[6])
            out_stall <= $urandom_range(0, 2) == 0;
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("heat_diffusion_stencil_step_core test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        operation   = OP_WRITE;
        cell_row    = '0;
        cell_col    = '0;
        write_value = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        steps_run   = 0;
        burst_left  = 0;
        step_count  = '0;
        k_col       = '0;
        k_row       = '0;
        src_row     = '0;
        src_col     = '0;
        src_temp    = 0;
        src_steps   = '0;
        foreach (temp_grid[i])
            temp_grid[i] = 0;

        dir_tab = '{
            '{OP_WRITE,  6'd0,  6'd0,  32'sh7FFFFFFF, 32'sh0},
            '{OP_WRITE,  6'd63, 6'd63, 32'sh80000000, 32'sh0},
            '{OP_WRITE,  6'd0,  6'd63, 32'sh0,        32'sh0},
            '{OP_WRITE,  6'd63, 6'd0,  32'shFFFFFFFF, 32'sh0},
            '{OP_READ,   6'd0,  6'd0,  32'sh0,        32'sh7FFFFFFF},
            '{OP_READ,   6'd63, 6'd63, 32'shFFFFFFFF, 32'sh80000000},
            '{OP_READ,   6'd0,  6'd63, 32'sh5A5A5A5A, 32'sh0},
            '{OP_READ,   6'd63, 6'd0,  32'sh0,        32'shFFFFFFFF},
            '{OP_UNUSED, 6'd17, 6'd42, 32'sh12345678, 32'sh0},
            '{OP_WRITE,  6'd31, 6'd31, 32'sh00010000, 32'sh0},
            '{OP_READ,   6'd31, 6'd31, 32'sh0,        32'sh00010000},
            '{OP_UNUSED, 6'd63, 6'd63, 32'shFFFFFFFF, 32'sh0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_word(dir_tab[i].op, dir_tab[i].row, dir_tab[i].col, dir_tab[i].wval,
                      1'b1, dir_tab[i].exp_temp);

        // load every cell before any step
        for (int i = 0; i < NCELL; i++)
            send_word(OP_WRITE, 6'(i / NCOL), 6'(i % NCOL),
                      $urandom_range(0, 7) == 0 ? $urandom() : 32'($urandom_range(0, 32'hFFFFF)),
                      1'b0, '0);
        wait_idle();

        // strongest coefficients, short-lived hot source
        write_reg(REG_COEF_COL, 32'h3FFFF);
        write_reg(REG_COEF_ROW, 32'h3FFFF);
        write_reg(REG_SOURCE_ROW, 32'd63);
        write_reg(REG_SOURCE_COL, 32'd0);
        write_reg(REG_SOURCE_TEMP, 32'h7FFFFFFF);
        write_reg(REG_SOURCE_STEPS, 32'd2);
        random_phase();
        wait_idle();

        // stable coefficients, source held for all steps
        write_reg(REG_COEF_COL, 32'h3333);
        write_reg(REG_COEF_ROW, 32'h1999);
        write_reg(REG_SOURCE_ROW, 32'd0);
        write_reg(REG_SOURCE_COL, 32'd63);
        write_reg(REG_SOURCE_TEMP, 32'h80000000);
        write_reg(REG_SOURCE_STEPS, 32'hFFFF);
        random_phase();
        wait_idle();

        // no diffusion, source already expired
        write_reg(REG_COEF_COL, 32'd0);
        write_reg(REG_COEF_ROW, 32'd0);
        write_reg(REG_SOURCE_ROW, 32'd32);
        write_reg(REG_SOURCE_COL, 32'd17);
        write_reg(REG_SOURCE_TEMP, 32'h00640000);
        write_reg(REG_SOURCE_STEPS, 32'd0);
        random_phase();
        wait_idle();

        $display("covered %0d result words and %0d grid steps over three register settings",
                 words_checked, steps_run);
        if (fail_count == 0)
            $display("heat_diffusion_stencil_step_core test passed");
        else
            $display("heat_diffusion_stencil_step_core test failed");
        $finish;
    end
endmodule
